### design/bdel_pkg.sv
// shared types, function and status codes for the bounded double-ended list
package bdel_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int ENTRY_WIDTH_DEF = 32;
    localparam int MAX_ENTRY_W     = 64;

    localparam logic [2:0] FUNC_PUSH_HEAD = 3'd0;
    localparam logic [2:0] FUNC_PUSH_TAIL = 3'd1;
    localparam logic [2:0] FUNC_POP_HEAD  = 3'd2;
    localparam logic [2:0] FUNC_POP_TAIL  = 3'd3;
    localparam logic [2:0] FUNC_READ      = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] entry_value;
        logic [7:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [8:0]  list_size;
        logic [31:0] head_value;
        logic [31:0] tail_value;
        logic [31:0] read_value;
        logic [1:0]  status;
    } t_rsp;

endpackage

### design/bounded_double_ended_list_core.sv
// Bounded double-ended list: a ring buffer in one synchronous memory with a
// head pointer and a size count; head and tail entries are also held in
// registers. For each item, in the accept cycle the push write or the
// single memory read (new head after a head pop, new tail after a tail pop,
// or the indexed entry) is issued, and in the next cycle the read data
// lands and the result is loaded into the output register. A new item is
// taken only in the idle state, once the output register is free or being
// emptied, so no new item is taken while the last one is in flight. Memory
// contents need no clearing after reset.
module bounded_double_ended_list_core #(
    parameter int CAPACITY    = bdel_pkg::CAPACITY_DEF,
    parameter int ENTRY_WIDTH = bdel_pkg::ENTRY_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  bdel_pkg::t_req i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output bdel_pkg::t_rsp o_out_data,
    input  logic           i_out_stall
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OFF_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int EW    = ENTRY_WIDTH;

    typedef enum logic {S_IDLE, S_RD} t_state;
    typedef enum logic [1:0] {P_NONE, P_HEAD, P_TAIL, P_READ} t_pend;

    t_state          r_state, n_state;
    t_pend           r_pend, n_pend;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_head, n_head;
    logic [EW-1:0]   r_head_val, n_head_val;
    logic [EW-1:0]   r_tail_val, n_tail_val;
    logic [1:0]      r_status, n_status;
    logic            r_out_valid, n_out_valid;
    bdel_pkg::t_rsp  r_out, n_out;

    logic             w_accept;
    logic             w_empty;
    logic             w_full;
    logic [OFF_W-1:0] w_offset;
    logic [OFF_W:0]   w_sum;
    logic [OFF_W:0]   w_wrap;
    logic [PTR_W-1:0] w_ring;
    logic [PTR_W-1:0] w_head_dec;
    logic             w_we;
    logic [PTR_W-1:0] w_waddr;
    logic [EW-1:0]    w_wdata;
    logic [EW-1:0]    w_rdata;

    function automatic logic [31:0] to_field(input logic [EW-1:0] v);
        logic [bdel_pkg::MAX_ENTRY_W-1:0] w;
        w = '0;
        w[EW-1:0] = v;
        return w[31:0];
    endfunction

    function automatic logic [EW-1:0] from_field(input logic [31:0] f);
        logic [bdel_pkg::MAX_ENTRY_W-1:0] w;
        w = '0;
        w[31:0] = f;
        return w[EW-1:0];
    endfunction

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    // ring position of an offset from the head
    always_comb begin
        case (i_in_data.func)
            bdel_pkg::FUNC_PUSH_TAIL: w_offset = OFF_W'(r_count);
            bdel_pkg::FUNC_POP_HEAD:  w_offset = OFF_W'(1);
            bdel_pkg::FUNC_POP_TAIL:  w_offset = OFF_W'(r_count) - OFF_W'(2);
            bdel_pkg::FUNC_READ:      w_offset = OFF_W'(i_in_data.read_index);
            default:                  w_offset = '0;
        endcase
    end

    assign w_sum  = {1'b0, OFF_W'(r_head)} + {1'b0, w_offset};
    assign w_wrap = (w_sum >= (OFF_W + 1)'(CAPACITY)) ? (w_sum - (OFF_W + 1)'(CAPACITY))
                                                      : w_sum;
    assign w_ring = w_wrap[PTR_W-1:0];
    assign w_head_dec = (r_head == '0) ? PTR_W'(CAPACITY - 1) : (r_head - PTR_W'(1));

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_count     = r_count;
        n_head      = r_head;
        n_head_val  = r_head_val;
        n_tail_val  = r_tail_val;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = w_ring;
        w_wdata     = from_field(i_in_data.entry_value);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_RD;
                    n_pend   = P_NONE;
                    n_status = bdel_pkg::ST_DONE;
                    case (i_in_data.func)
                        bdel_pkg::FUNC_PUSH_HEAD: begin
                            if (w_full) begin
                                n_status = bdel_pkg::ST_FULL;
                            end else begin
                                w_we       = 1'b1;
                                w_waddr    = w_head_dec;
                                n_head     = w_head_dec;
                                n_head_val = w_wdata;
                                if (w_empty) begin
                                    n_tail_val = w_wdata;
                                end
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        bdel_pkg::FUNC_PUSH_TAIL: begin
                            if (w_full) begin
                                n_status = bdel_pkg::ST_FULL;
                            end else begin
                                w_we       = 1'b1;
                                n_tail_val = w_wdata;
                                if (w_empty) begin
                                    n_head_val = w_wdata;
                                end
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        bdel_pkg::FUNC_POP_HEAD: begin
                            if (w_empty) begin
                                n_status = bdel_pkg::ST_EMPTY;
                            end else begin
                                n_head  = w_ring;
                                n_count = r_count - CNT_W'(1);
                                // memory read of the new head lands next cycle
                                if (r_count != CNT_W'(1)) begin
                                    n_pend = P_HEAD;
                                end
                            end
                        end
                        bdel_pkg::FUNC_POP_TAIL: begin
                            if (w_empty) begin
                                n_status = bdel_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (r_count != CNT_W'(1)) begin
                                    n_pend = P_TAIL;
                                end
                            end
                        end
                        bdel_pkg::FUNC_READ: begin
                            if (OFF_W'(i_in_data.read_index) >= OFF_W'(r_count)) begin
                                n_status = bdel_pkg::ST_RANGE;
                            end else begin
                                n_pend = P_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_IDLE;
                if (r_pend == P_HEAD) begin
                    n_head_val = w_rdata;
                end
                if (r_pend == P_TAIL) begin
                    n_tail_val = w_rdata;
                end
                n_out.list_size  = 9'(r_count);
                n_out.head_value = (r_count == '0) ? 32'd0 : to_field(n_head_val);
                n_out.tail_value = (r_count == '0) ? 32'd0 : to_field(n_tail_val);
                n_out.read_value = (r_pend == P_READ) ? to_field(w_rdata) : 32'd0;
                n_out.status     = r_status;
                n_out_valid      = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= P_NONE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
        r_head_val <= n_head_val;
        r_tail_val <= n_tail_val;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    bdel_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_ring),
        .o_rdata (w_rdata)
    );

endmodule

### design/bdel_mem.sv
// entry storage: one write port, one read port with registered read data
module bdel_mem #(
    parameter int DEPTH = bdel_pkg::CAPACITY_DEF,
    parameter int WIDTH = bdel_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
